@@ src/sog_pkg.sv @@
// Shared types, constants and helpers for the spiral order address generator.
`default_nettype none

package sog_pkg;

  localparam int MAX_DIM = 64;
  localparam int DIM_W   = 7;   // holds 0..MAX_DIM
  localparam int IDX_W   = 6;   // row / column index
  localparam int CNT_W   = 13;  // holds 0..MAX_DIM*MAX_DIM
  localparam int ADDR_W  = 12;
  localparam int START_W = 16;
  localparam int VALUE_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 2'd2;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] top;
    logic [DIM_W-1:0] bottom;
    logic [IDX_W-1:0] left;
    logic [DIM_W-1:0] right;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [1:0]       dir;
    logic [CNT_W-1:0] done;
  } spiral_t;

  // Out-of-range dimensions: zero reads as one, anything above the max as the max.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  function automatic spiral_t begin_spiral(input logic [DIM_W-1:0] rows,
                                           input logic [DIM_W-1:0] cols);
    spiral_t s;
    s.top    = '0;
    s.left   = '0;
    s.bottom = rows - DIM_W'(1);
    s.right  = cols - DIM_W'(1);
    s.row    = '0;
    s.col    = '0;
    s.dir    = DIR_RIGHT;
    s.done   = '0;
    return s;
  endfunction

endpackage

`default_nettype wire

@@ src/sog_step.sv @@
// One spiral step: current cell fields and the position of the next cell.
`default_nettype none

module sog_step (
  input  wire sog_pkg::spiral_t                  cur,
  input  wire                                    restart,
  input  wire logic [sog_pkg::DIM_W-1:0]         rows,
  input  wire logic [sog_pkg::DIM_W-1:0]         cols,
  input  wire logic [sog_pkg::CNT_W-1:0]         total,
  input  wire logic [sog_pkg::START_W-1:0]       start_value,
  output sog_pkg::spiral_t                       nxt,
  output logic [sog_pkg::IDX_W-1:0]              cell_row,
  output logic [sog_pkg::IDX_W-1:0]              cell_column,
  output logic [sog_pkg::ADDR_W-1:0]             cell_address,
  output logic [sog_pkg::VALUE_W-1:0]            cell_value,
  output logic                                   last_cell
);

  sog_pkg::spiral_t                  eff;
  sog_pkg::spiral_t                  shrunk;
  logic [sog_pkg::DIM_W-1:0]         row_x;
  logic [sog_pkg::DIM_W-1:0]         col_x;
  logic [sog_pkg::DIM_W-1:0]         top_x;
  logic [sog_pkg::DIM_W-1:0]         left_x;
  logic [sog_pkg::DIM_W+sog_pkg::IDX_W-1:0] prod;

  always_comb begin
    // Restart, or an advance after the last cell, starts over at the corner.
    if (restart || (cur.done >= total)) eff = sog_pkg::begin_spiral(rows, cols);
    else eff = cur;
  end

  assign row_x  = {1'b0, eff.row};
  assign col_x  = {1'b0, eff.col};
  assign top_x  = {1'b0, eff.top};
  assign left_x = {1'b0, eff.left};

  assign prod         = eff.row * cols;
  assign cell_row     = eff.row;
  assign cell_column  = eff.col;
  assign cell_address = prod[sog_pkg::ADDR_W-1:0] + {{(sog_pkg::ADDR_W-sog_pkg::IDX_W){1'b0}}, eff.col};
  assign cell_value   = {1'b0, start_value} +
                        {{(sog_pkg::VALUE_W-sog_pkg::CNT_W){1'b0}}, eff.done};
  assign last_cell    = ((eff.done + sog_pkg::CNT_W'(1)) == total);

  always_comb begin
    shrunk        = eff;
    shrunk.top    = eff.top + sog_pkg::IDX_W'(1);
    shrunk.left   = eff.left + sog_pkg::IDX_W'(1);
    shrunk.bottom = eff.bottom - sog_pkg::DIM_W'(1);
    shrunk.right  = eff.right - sog_pkg::DIM_W'(1);
    shrunk.dir    = sog_pkg::DIR_RIGHT;
    shrunk.row    = eff.top + sog_pkg::IDX_W'(1);
    shrunk.col    = eff.left + sog_pkg::IDX_W'(1);
  end

  always_comb begin
    nxt      = eff;
    nxt.done = eff.done + sog_pkg::CNT_W'(1);
    if (!last_cell) begin
      unique case (eff.dir)
        sog_pkg::DIR_RIGHT: begin
          if (col_x < eff.right) nxt.col = eff.col + sog_pkg::IDX_W'(1);
          else if (top_x < eff.bottom) begin
            nxt.dir = sog_pkg::DIR_DOWN;
            nxt.row = eff.row + sog_pkg::IDX_W'(1);
          end else begin
            nxt      = shrunk;
            nxt.done = eff.done + sog_pkg::CNT_W'(1);
          end
        end
        sog_pkg::DIR_DOWN: begin
          if (row_x < eff.bottom) nxt.row = eff.row + sog_pkg::IDX_W'(1);
          else if (left_x < eff.right) begin
            nxt.dir = sog_pkg::DIR_LEFT;
            nxt.col = eff.col - sog_pkg::IDX_W'(1);
          end else begin
            nxt      = shrunk;
            nxt.done = eff.done + sog_pkg::CNT_W'(1);
          end
        end
        sog_pkg::DIR_LEFT: begin
          if (eff.col > eff.left) nxt.col = eff.col - sog_pkg::IDX_W'(1);
          else if (eff.bottom > (top_x + sog_pkg::DIM_W'(1))) begin
            // single row rings never reach here: the up pass needs three rows or more in the ring
            nxt.dir = sog_pkg::DIR_UP;
            nxt.row = eff.row - sog_pkg::IDX_W'(1);
          end else begin
            nxt      = shrunk;
            nxt.done = eff.done + sog_pkg::CNT_W'(1);
          end
        end
        default: begin
          if (row_x > (top_x + sog_pkg::DIM_W'(1))) nxt.row = eff.row - sog_pkg::IDX_W'(1);
          else begin
            nxt      = shrunk;
            nxt.done = eff.done + sog_pkg::CNT_W'(1);
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/spiral_order_address_generator.sv @@
// Spiral order address generator: top level with config registers and output stage.
// Usage
//   Each request on the in_ channel (in_valid/in_ready) yields exactly one cell on
//   the out_ channel: row, column, row-major address, start value plus ordinal and a
//   last-cell flag, in clockwise spiral order over num_rows x num_columns.
//   in_restart = 1 makes that request emit the top-left corner of a new spiral; an
//   advance after the last cell also starts over.
//   The cell is registered: it is in the output register the cycle after the request
//   is taken. One cell per clock while the receiver does not stall, set by the single
//   step of bound compares and increments between the position registers and the output
//   register.
//   When the receiver stalls, the output register holds its cell and in_ready drops
//   only while that register is full and out_ready is low; a request is taken in the
//   same cycle that the held cell leaves.
//   Configuration: cfg_we with cfg_index 0 (rows), 1 (columns), 2 (start value)
//   writes the register and restarts the spiral; index 3 is ignored. Write only when
//   no request is outstanding.
//   Reset (rst_n low, synchronous) loads 8 x 8 with start value 1 and empties the
//   output register.
`default_nettype none

module spiral_order_address_generator (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire logic [sog_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sog_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   in_restart,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [sog_pkg::IDX_W-1:0]             out_cell_row,
  output logic [sog_pkg::IDX_W-1:0]             out_cell_column,
  output logic [sog_pkg::ADDR_W-1:0]            out_cell_address,
  output logic [sog_pkg::VALUE_W-1:0]           out_cell_value,
  output logic                                  out_last_cell
);

  logic [sog_pkg::DIM_W-1:0]   num_rows_r, num_rows_nxt;
  logic [sog_pkg::DIM_W-1:0]   num_columns_r, num_columns_nxt;
  logic [sog_pkg::START_W-1:0] start_value_r, start_value_nxt;
  logic [sog_pkg::CNT_W-1:0]   total_r, total_nxt;
  sog_pkg::spiral_t            st_r, st_nxt, step_nxt;
  logic [sog_pkg::DIM_W-1:0]   rows_c, cols_c, rows_new, cols_new;
  logic [2*sog_pkg::DIM_W-1:0] total_prod;
  logic                        cfg_hit;
  logic                        accept;
  logic                        out_valid_r;
  logic [sog_pkg::IDX_W-1:0]   row_d, col_d;
  logic [sog_pkg::ADDR_W-1:0]  addr_d;
  logic [sog_pkg::VALUE_W-1:0] value_d;
  logic                        last_d;
  logic [sog_pkg::IDX_W-1:0]   row_r, col_r;
  logic [sog_pkg::ADDR_W-1:0]  addr_r;
  logic [sog_pkg::VALUE_W-1:0] value_r;
  logic                        last_r;

  assign rows_c   = sog_pkg::clamp_dim(num_rows_r);
  assign cols_c   = sog_pkg::clamp_dim(num_columns_r);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  sog_step u_step (
    .cur          (st_r),
    .restart      (in_restart),
    .rows         (rows_c),
    .cols         (cols_c),
    .total        (total_r),
    .start_value  (start_value_r),
    .nxt          (step_nxt),
    .cell_row     (row_d),
    .cell_column  (col_d),
    .cell_address (addr_d),
    .cell_value   (value_d),
    .last_cell    (last_d)
  );

  always_comb begin
    num_rows_nxt    = num_rows_r;
    num_columns_nxt = num_columns_r;
    start_value_nxt = start_value_r;
    cfg_hit         = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        sog_pkg::REG_NUM_ROWS: begin
          num_rows_nxt = cfg_data[sog_pkg::DIM_W-1:0];
          cfg_hit      = 1'b1;
        end
        sog_pkg::REG_NUM_COLUMNS: begin
          num_columns_nxt = cfg_data[sog_pkg::DIM_W-1:0];
          cfg_hit         = 1'b1;
        end
        sog_pkg::REG_START_VALUE: begin
          start_value_nxt = cfg_data[sog_pkg::START_W-1:0];
          cfg_hit         = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    rows_new   = sog_pkg::clamp_dim(num_rows_nxt);
    cols_new   = sog_pkg::clamp_dim(num_columns_nxt);
    total_prod = rows_new * cols_new;
    total_nxt  = cfg_hit ? total_prod[sog_pkg::CNT_W-1:0] : total_r;
    if (cfg_hit) st_nxt = sog_pkg::begin_spiral(rows_new, cols_new);
    else if (accept) st_nxt = step_nxt;
    else st_nxt = st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r    <= sog_pkg::DIM_W'(8);
      num_columns_r <= sog_pkg::DIM_W'(8);
      start_value_r <= sog_pkg::START_W'(1);
      total_r       <= sog_pkg::CNT_W'(64);
      st_r          <= sog_pkg::begin_spiral(sog_pkg::DIM_W'(8), sog_pkg::DIM_W'(8));
      out_valid_r   <= 1'b0;
    end else begin
      num_rows_r    <= num_rows_nxt;
      num_columns_r <= num_columns_nxt;
      start_value_r <= start_value_nxt;
      total_r       <= total_nxt;
      st_r          <= st_nxt;
      if (accept) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_r   <= row_d;
      col_r   <= col_d;
      addr_r  <= addr_d;
      value_r <= value_d;
      last_r  <= last_d;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_row     = row_r;
  assign out_cell_column  = col_r;
  assign out_cell_address = addr_r;
  assign out_cell_value   = value_r;
  assign out_last_cell    = last_r;

endmodule

`default_nettype wire

@@ tb/sv/spiral_scoreboard_pkg.sv @@
// Cell predictor and result checker for the spiral order address generator testbench.
package spiral_scoreboard_pkg;

  typedef struct packed {
    logic [sog_pkg::IDX_W-1:0]   row;
    logic [sog_pkg::IDX_W-1:0]   column;
    logic [sog_pkg::ADDR_W-1:0]  address;
    logic [sog_pkg::VALUE_W-1:0] value;
    logic                        last;
  } spiral_cell_t;

  class spiral_scoreboard;
    logic [sog_pkg::DIM_W-1:0]   rows_reg;
    logic [sog_pkg::DIM_W-1:0]   cols_reg;
    logic [sog_pkg::START_W-1:0] start_reg;

    logic [sog_pkg::IDX_W-1:0]   top_edge;
    logic [sog_pkg::DIM_W-1:0]   bottom_edge;
    logic [sog_pkg::IDX_W-1:0]   left_edge;
    logic [sog_pkg::DIM_W-1:0]   right_edge;
    logic [sog_pkg::IDX_W-1:0]   cur_row;
    logic [sog_pkg::IDX_W-1:0]   cur_col;
    logic [1:0]                  heading;
    logic [sog_pkg::CNT_W-1:0]   cells_done;

    spiral_cell_t cells_due[$];
    int mismatches;
    int requests;
    int restarts;
    int spirals_done;
    int cells_seen;

    function new();
      rows_reg  = sog_pkg::DIM_W'(8);
      cols_reg  = sog_pkg::DIM_W'(8);
      start_reg = sog_pkg::START_W'(1);
      restart_ring();
    endfunction

    // zero acts as one, anything past the max as the max
    function int unsigned dim_in_use(logic [sog_pkg::DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > sog_pkg::MAX_DIM) return sog_pkg::MAX_DIM;
      return v;
    endfunction

    function int unsigned spiral_size();
      return dim_in_use(rows_reg) * dim_in_use(cols_reg);
    endfunction

    function void restart_ring();
      top_edge    = '0;
      left_edge   = '0;
      bottom_edge = sog_pkg::DIM_W'(dim_in_use(rows_reg) - 1);
      right_edge  = sog_pkg::DIM_W'(dim_in_use(cols_reg) - 1);
      cur_row     = '0;
      cur_col     = '0;
      heading     = sog_pkg::DIR_RIGHT;
      cells_done  = '0;
    endfunction

    function void step_inward();
      top_edge++;
      left_edge++;
      bottom_edge--;
      right_edge--;
      heading = sog_pkg::DIR_RIGHT;
      cur_row = top_edge;
      cur_col = left_edge;
    endfunction

    // single-row or single-column rings fall through to step_inward
    function void advance();
      case (heading)
        sog_pkg::DIR_RIGHT: begin
          if (cur_col < right_edge) cur_col++;
          else if (top_edge < bottom_edge) begin
            heading = sog_pkg::DIR_DOWN;
            cur_row++;
          end else step_inward();
        end
        sog_pkg::DIR_DOWN: begin
          if (cur_row < bottom_edge) cur_row++;
          else if (left_edge < right_edge) begin
            heading = sog_pkg::DIR_LEFT;
            cur_col--;
          end else step_inward();
        end
        sog_pkg::DIR_LEFT: begin
          if (cur_col > left_edge) cur_col--;
          else if (bottom_edge > top_edge + 1) begin
            heading = sog_pkg::DIR_UP;
            cur_row--;
          end else step_inward();
        end
        default: begin
          if (cur_row > top_edge + 1) cur_row--;
          else step_inward();
        end
      endcase
    endfunction

    function void note_request(bit restart);
      int unsigned total;
      int unsigned row_u;
      int unsigned col_u;
      int unsigned sum;
      spiral_cell_t c;
      total = spiral_size();
      requests++;
      if (restart) restarts++;
      if (restart || cells_done >= total) restart_ring();
      row_u = cur_row;
      col_u = cur_col;
      sum = start_reg;
      sum += cells_done;
      c.row     = cur_row;
      c.column  = cur_col;
      c.address = sog_pkg::ADDR_W'(row_u * dim_in_use(cols_reg) + col_u);
      c.value   = sog_pkg::VALUE_W'(sum);
      c.last    = (cells_done + 1 == total);
      if (c.last) spirals_done++;
      cells_due.push_back(c);
      cells_done++;
      if (!c.last) advance();
    endfunction

    function void write_register(logic [sog_pkg::CFG_IDX_W-1:0] idx,
                                 logic [sog_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sog_pkg::REG_NUM_ROWS:    rows_reg = data[sog_pkg::DIM_W-1:0];
        sog_pkg::REG_NUM_COLUMNS: cols_reg = data[sog_pkg::DIM_W-1:0];
        sog_pkg::REG_START_VALUE: start_reg = data;
        default:                  return;
      endcase
      restart_ring();
    endfunction

    function int pending();
      return cells_due.size();
    endfunction

    function void check_cell(spiral_cell_t got);
      spiral_cell_t want;
      cells_seen++;
      if (cells_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: cell row %0d col %0d arrived with no request pending",
                   got.row, got.column);
        return;
      end
      want = cells_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: cell %0d expected row %0d col %0d addr %0d value %0d last %0d,",
                    " got row %0d col %0d addr %0d value %0d last %0d"},
                   cells_seen, want.row, want.column, want.address, want.value, want.last,
                   got.row, got.column, got.address, got.value, got.last);
      end
    endfunction
  endclass

endpackage

@@ tb/sv/testbench.sv @@
// Top-level testbench: drives requests and register writes, checks every emitted cell.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [sog_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int LONG_HOLD       = 48;
  localparam int RANDOM_REQUESTS = 1250;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [sog_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sog_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_restart = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [sog_pkg::IDX_W-1:0] out_cell_row;
  logic [sog_pkg::IDX_W-1:0] out_cell_column;
  logic [sog_pkg::ADDR_W-1:0] out_cell_address;
  logic [sog_pkg::VALUE_W-1:0] out_cell_value;
  logic out_last_cell;

  spiral_scoreboard_pkg::spiral_scoreboard sb;
  spiral_scoreboard_pkg::spiral_cell_t seen_cell;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  int holds = 0;
  int settings_used = 1;
  int cycle_count = 0;

  spiral_order_address_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_row     (out_cell_row),
    .out_cell_column  (out_cell_column),
    .out_cell_address (out_cell_address),
    .out_cell_value   (out_cell_value),
    .out_last_cell    (out_last_cell)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // handshakes are sampled with pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_restart);
      if (out_valid && out_ready) begin
        seen_cell.row     = out_cell_row;
        seen_cell.column  = out_cell_column;
        seen_cell.address = out_cell_address;
        seen_cell.value   = out_cell_value;
        seen_cell.last    = out_last_cell;
        sb.check_cell(seen_cell);
      end
    end
  end

  // receiver: random stalls, one long hold-off on request, none once quiet
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        holds++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  task automatic send_request(input bit restart);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait until every request has produced its cell
  task automatic drain_requests();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  task automatic write_cfg(input logic [sog_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sog_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_register(idx, data);
  endtask

  task automatic configure(input logic [sog_pkg::CFG_DATA_W-1:0] rows, cols, start);
    drain_requests();
    write_cfg(sog_pkg::REG_NUM_ROWS, rows);
    write_cfg(sog_pkg::REG_NUM_COLUMNS, cols);
    write_cfg(sog_pkg::REG_START_VALUE, start);
    if ($urandom_range(0, 7) == 0) write_cfg(REG_UNUSED, sog_pkg::CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mostly small matrices, some up to the max, a few raw values that need clamping
  function automatic logic [sog_pkg::CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return sog_pkg::CFG_DATA_W'($urandom);
      1, 2:    return sog_pkg::CFG_DATA_W'($urandom_range(9, sog_pkg::MAX_DIM));
      default: return sog_pkg::CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    int random_sent;
    int batch;
    random_sent = 0;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings (8 x 8, start 1), restart mid-spiral
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);

    // write to an unused index must not disturb the spiral
    drain_requests();
    write_cfg(REG_UNUSED, '1);
    cfg_we <= 1'b0;
    send_request(1'b0);

    // zero rows reads as one: 1 x 1 wraps on every request, max start value
    configure('0, sog_pkg::CFG_DATA_W'(1), '1);
    repeat (3) send_request(1'b0);

    // 2 x 3 from zero, one past the end to wrap around
    configure(sog_pkg::CFG_DATA_W'(2), sog_pkg::CFG_DATA_W'(3), '0);
    repeat (7) send_request(1'b0);

    // oversized dimensions clamp to the max
    configure(sog_pkg::CFG_DATA_W'(sog_pkg::MAX_DIM + 1), '1,
              sog_pkg::CFG_DATA_W'(16'h8000));
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);

    // random phases: mostly whole spirals walked through, occasional restarts
    while (random_sent < RANDOM_REQUESTS) begin
      configure(pick_dim(), pick_dim(), sog_pkg::CFG_DATA_W'($urandom));
      batch = sb.spiral_size() * $urandom_range(1, 3) + $urandom_range(0, 4);
      if (batch > 160) batch = $urandom_range(40, 160);
      if (batch > RANDOM_REQUESTS - random_sent) batch = RANDOM_REQUESTS - random_sent;
      repeat (batch) begin
        send_request($urandom_range(0, 24) == 0);
        random_sent++;
        if (random_sent == 300) hold_request = 1'b1;
        if (random_sent >= RANDOM_REQUESTS - 200) quiet = 1'b1;
      end
    end

    drain_requests();
    repeat (4) @(posedge clk);
    $display("Run covered %0d requests over %0d settings, %0d complete spirals, %0d restarts.",
             sb.requests, settings_used, sb.spirals_done, sb.restarts);
    $display("Cells checked: %0d, long receiver hold-offs: %0d, mismatches: %0d.",
             sb.cells_seen, holds, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/sog_pkg.sv
src/sog_step.sv
src/spiral_order_address_generator.sv
tb/sv/spiral_scoreboard_pkg.sv
tb/sv/testbench.sv
